// File: hdl/assert_macros.svh
// Assertion macros used by the checker module of the bitmap row pixel decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BRPD_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BRPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/brpd_pkg.sv
// Types, constants and helper functions shared by the bitmap row pixel decoder.
package brpd_pkg;

   // Configuration register indexes.
   localparam logic [2:0] CSR_BITS_PER_PIXEL = 3'd0;
   localparam logic [2:0] CSR_INDEXED_MODE   = 3'd1;
   localparam logic [2:0] CSR_PALETTE_COUNT  = 3'd2;
   localparam logic [2:0] CSR_IMAGE_WIDTH    = 3'd3;
   localparam logic [2:0] CSR_RED_MASK       = 3'd4;
   localparam logic [2:0] CSR_GREEN_MASK     = 3'd5;
   localparam logic [2:0] CSR_BLUE_MASK      = 3'd6;
   localparam logic [2:0] CSR_ALPHA_MASK     = 3'd7;

   // Input command codes.
   localparam logic CMD_PALETTE_WRITE = 1'b0;
   localparam logic CMD_ROW_BYTE      = 1'b1;

   // Job queue depth between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      JOB_PALETTE = 2'd0,
      JOB_INDEXED = 2'd1,
      JOB_DIRECT  = 2'd2
   } job_kind_type;

   // One queued job. Palette write: data = {index, color}. Indexed byte:
   // data[7:0] = byte, count = pixels to emit. Direct pixel: data = pixel word.
   typedef struct packed {
      job_kind_type kind;
      logic [31:0]  data;
      logic [15:0]  column;
      logic [3:0]   count;
   } job_type;

   typedef struct packed {
      logic [5:0]  bpp;
      logic        indexed;
      logic [8:0]  pcount;
      logic [15:0] width;
      logic [31:0] red_mask;
      logic [31:0] green_mask;
      logic [31:0] blue_mask;
      logic [31:0] alpha_mask;
   } cfg_type;

   // Where a channel sits in the pixel word, derived from its mask.
   typedef struct packed {
      logic       empty;
      logic [4:0] shift;
      logic [3:0] nbits;
   } chan_type;

   // Log2 of the indexed pixel depth: 1, 2 and 4 stand, anything else acts as 8.
   function automatic logic [1:0] eff_lg(input logic [5:0] bpp);
      logic [1:0] lg;
      unique case (bpp)
         6'd1:    lg = 2'd0;
         6'd2:    lg = 2'd1;
         6'd4:    lg = 2'd2;
         default: lg = 2'd3;
      endcase
      return lg;
   endfunction

   // Bytes per direct pixel: 2, 3 or 4.
   function automatic logic [2:0] direct_bpb(input logic [5:0] bpp);
      logic [2:0] n;
      if (bpp <= 6'd16) begin
         n = 3'd2;
      end else if (bpp <= 6'd24) begin
         n = 3'd3;
      end else begin
         n = 3'd4;
      end
      return n;
   endfunction

   // Finds the top run of ones in a mask, keeping at most its upper 8 bits.
   function automatic chan_type chan_params(input logic [31:0] mask);
      chan_type   c;
      logic [4:0] top;
      logic [3:0] run;
      logic       going;
      logic [5:0] pos;
      top   = '0;
      run   = '0;
      going = 1'b1;
      for (int k = 0; k < 32; k++) begin
         if (mask[k]) begin
            top = 5'(k);
         end
      end
      for (int k = 0; k < 8; k++) begin
         pos = {1'b0, top} - 6'(k);
         if (going && !pos[5] && mask[pos[4:0]]) begin
            run = run + 4'd1;
         end else begin
            going = 1'b0;
         end
      end
      c.empty = (mask == '0);
      c.nbits = run;
      c.shift = top - 5'(run) + 5'd1;
      return c;
   endfunction

   // Cuts a channel out of the pixel word and widens it to 8 bits by replication.
   function automatic logic [7:0] chan_extract(input logic [31:0] pix, input chan_type c);
      logic [31:0] sh;
      logic [7:0]  keep;
      logic [7:0]  v;
      logic [4:0]  b;
      sh   = pix >> c.shift;
      keep = 8'hFF >> (4'd8 - c.nbits);
      v    = sh[7:0] & keep;
      v    = v << (4'd8 - c.nbits);
      b    = 5'(c.nbits);
      for (int k = 0; k < 3; k++) begin
         if (b < 5'd8) begin
            v = v | (v >> b);
            b = b << 1;
         end
      end
      return v;
   endfunction

endpackage

// File: hdl/brpd_front.sv
// Front end: accepts input items, tracks row position and turns each item into a job.
module brpd_front import brpd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [7:0]  req_data_byte,
   input  logic [7:0]  req_palette_index,
   input  logic [23:0] req_palette_color,
   input  cfg_type     cfg,
   input  logic        q_full,
   output logic        q_push,
   output job_type     q_job
);

   logic [23:0] acc_ff, acc_in;
   logic [1:0]  bip_ff, bip_in;
   logic [15:0] col_ff, col_in;
   logic [17:0] bir_ff, bir_in;

   logic        accept;
   logic [1:0]  lg;
   logic [2:0]  bpb;
   logic [20:0] wbits;
   logic [21:0] wsum;
   logic [17:0] row_span;
   logic        row_end;
   logic        col_live;
   logic [15:0] rem;
   logic [3:0]  per;
   logic [3:0]  n;
   logic [31:0] pix;

   assign req_stall = q_full;

   always_comb begin
      accept = req_valid && !q_full;
      lg     = eff_lg(cfg.bpp);
      bpb    = direct_bpb(cfg.bpp);

      if (cfg.indexed) begin
         wbits = 21'(cfg.width) << lg;
      end else begin
         case (bpb)
            3'd2:    wbits = 21'(cfg.width) << 4;
            3'd3:    wbits = (21'(cfg.width) << 4) + (21'(cfg.width) << 3);
            default: wbits = 21'(cfg.width) << 5;
         endcase
      end
      wsum     = 22'(wbits) + 22'd31;
      row_span = (cfg.width == '0) ? 18'd4 : {wsum[20:5], 2'b00};
      row_end  = ({1'b0, bir_ff} + 19'd1) >= {1'b0, row_span};

      col_live = col_ff < cfg.width;
      rem      = cfg.width - col_ff;
      per      = 4'd8 >> lg;
      n        = (rem < 16'(per)) ? rem[3:0] : per;
      pix      = {8'b0, acc_ff} | (32'(req_data_byte) << {bip_ff, 3'b000});

      acc_in = acc_ff;
      bip_in = bip_ff;
      col_in = col_ff;
      bir_in = bir_ff;
      q_push = 1'b0;
      q_job  = '{kind: JOB_PALETTE, data: '0, column: col_ff, count: '0};

      if (accept) begin
         if (req_command == CMD_PALETTE_WRITE) begin
            q_push     = 1'b1;
            q_job.data = {req_palette_index, req_palette_color};
         end else begin
            if (cfg.indexed) begin
               if (col_live) begin
                  q_push      = 1'b1;
                  q_job.kind  = JOB_INDEXED;
                  q_job.data  = {24'b0, req_data_byte};
                  q_job.count = n;
                  col_in      = col_ff + 16'(n);
               end
            end else if (col_live) begin
               if (({1'b0, bip_ff} + 3'd1) >= bpb) begin
                  q_push      = 1'b1;
                  q_job.kind  = JOB_DIRECT;
                  q_job.data  = pix;
                  q_job.count = 4'd1;
                  col_in      = col_ff + 16'd1;
                  acc_in      = '0;
                  bip_in      = '0;
               end else begin
                  acc_in = acc_ff | 24'(32'(req_data_byte) << {bip_ff, 3'b000});
                  bip_in = bip_ff + 2'd1;
               end
            end

            // Padding bytes close the row once the padded length is reached.
            if (row_end) begin
               bir_in = '0;
               col_in = '0;
               bip_in = '0;
               acc_in = '0;
            end else begin
               bir_in = bir_ff + 18'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         bip_ff <= '0;
         col_ff <= '0;
         bir_ff <= '0;
      end else begin
         acc_ff <= acc_in;
         bip_ff <= bip_in;
         col_ff <= col_in;
         bir_ff <= bir_in;
      end
   end

endmodule

// File: hdl/brpd_job_queue.sv
// Short job queue between the front and back ends.
module brpd_job_queue import brpd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

   job_type             slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   always_comb begin
      full       = count_ff == (QUEUE_AW + 1)'(QUEUE_DEPTH);
      head_valid = count_ff != '0;
      head_job   = slot_ff[rd_ptr_ff];
      do_push    = push && !full;
      do_pop     = pop && head_valid;
      wr_ptr_in  = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in  = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in   = count_ff + (QUEUE_AW + 1)'(do_push) - (QUEUE_AW + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: hdl/brpd_back.sv
// Back end: palette store, per-pixel issue, channel unpacking and the result register.
module brpd_back import brpd_pkg::*; #(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        q_valid,
   input  job_type     q_head,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_pixel_argb,
   output logic [15:0] rsp_pixel_column,
   output logic        rsp_row_done,
   output logic        rsp_index_out_of_range,
   output logic        rsp_last
);

   localparam int AW = $clog2(PALETTE_DEPTH);

   logic [23:0] pal_mem [PALETTE_DEPTH];
   logic [23:0] rd_ff;

   chan_type    red_ff, green_ff, blue_ff, alpha_ff;

   logic [2:0]  sub_ff, sub_in;
   logic        b_valid_ff;
   logic        b_direct_ff;
   logic        b_oor_ff;
   logic [31:0] b_pix_ff;
   logic [15:0] b_col_ff;
   logic        b_row_done_ff;
   logic        b_last_ff;

   logic        rsp_valid_ff;
   logic [31:0] rsp_argb_ff;
   logic [15:0] rsp_col_ff;
   logic        rsp_row_done_ff;
   logic        rsp_oor_ff;
   logic        rsp_last_ff;

   logic        adv;
   logic [1:0]  lg;
   logic [5:0]  amt;
   logic [7:0]  sh;
   logic [7:0]  idx;
   logic [8:0]  count9;
   logic        oor;
   logic        last_sub;
   logic [15:0] col;
   logic        is_pal;
   logic        is_ind;
   logic        is_dir;
   logic        issue_pix;
   logic        pal_wr;
   logic [31:0] argb;

   always_comb begin
      adv    = !rsp_valid_ff || !rsp_stall;
      is_pal = q_head.kind == JOB_PALETTE;
      is_ind = q_head.kind == JOB_INDEXED;
      is_dir = q_head.kind == JOB_DIRECT;

      // Pixels come out of the byte most significant first.
      lg  = eff_lg(cfg.bpp);
      amt = 6'(sub_ff) << lg;
      sh  = q_head.data[7:0] << amt;
      unique case (lg)
         2'd0:    idx = {7'b0, sh[7]};
         2'd1:    idx = {6'b0, sh[7:6]};
         2'd2:    idx = {4'b0, sh[7:4]};
         default: idx = sh;
      endcase
      count9 = (cfg.pcount < 9'(PALETTE_DEPTH)) ? cfg.pcount : 9'(PALETTE_DEPTH);
      oor    = {1'b0, idx} >= count9;

      last_sub  = ({1'b0, sub_ff} + 4'd1) == q_head.count;
      col       = q_head.column + 16'(sub_ff);
      issue_pix = adv && q_valid && (is_ind || is_dir);
      pal_wr    = adv && q_valid && is_pal && ({1'b0, q_head.data[31:24]} < 9'(PALETTE_DEPTH));
      q_pop     = adv && q_valid && (!is_ind || last_sub);

      sub_in = sub_ff;
      if (adv && q_valid && is_ind) begin
         sub_in = last_sub ? 3'd0 : sub_ff + 3'd1;
      end

      if (b_direct_ff) begin
         argb[31:24] = alpha_ff.empty ? 8'hFF : chan_extract(b_pix_ff, alpha_ff);
         argb[23:16] = red_ff.empty ? 8'h00 : chan_extract(b_pix_ff, red_ff);
         argb[15:8]  = green_ff.empty ? 8'h00 : chan_extract(b_pix_ff, green_ff);
         argb[7:0]   = blue_ff.empty ? 8'h00 : chan_extract(b_pix_ff, blue_ff);
      end else if (b_oor_ff) begin
         argb = '0;
      end else begin
         argb = {8'hFF, rd_ff};
      end
   end

   // Channel positions are registered from the mask registers and follow them in the next cycle.
   always_ff @(posedge clock) begin
      red_ff   <= chan_params(cfg.red_mask);
      green_ff <= chan_params(cfg.green_mask);
      blue_ff  <= chan_params(cfg.blue_mask);
      alpha_ff <= chan_params(cfg.alpha_mask);
   end

   always_ff @(posedge clock) begin
      if (pal_wr) begin
         pal_mem[q_head.data[24 +: AW]] <= q_head.data[23:0];
      end
   end

   always_ff @(posedge clock) begin
      if (issue_pix && is_ind) begin
         rd_ff <= pal_mem[idx[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff       <= '0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sub_ff <= sub_in;
         if (adv) begin
            b_valid_ff   <= issue_pix;
            rsp_valid_ff <= b_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_direct_ff     <= is_dir;
         b_oor_ff        <= is_ind && oor;
         b_pix_ff        <= q_head.data;
         b_col_ff        <= col;
         b_row_done_ff   <= ({1'b0, col} + 17'd1) == {1'b0, cfg.width};
         b_last_ff       <= is_dir || last_sub;
         rsp_argb_ff     <= argb;
         rsp_col_ff      <= b_col_ff;
         rsp_row_done_ff <= b_row_done_ff;
         rsp_oor_ff      <= b_oor_ff;
         rsp_last_ff     <= b_last_ff;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_pixel_argb         = rsp_argb_ff;
   assign rsp_pixel_column       = rsp_col_ff;
   assign rsp_row_done           = rsp_row_done_ff;
   assign rsp_index_out_of_range = rsp_oor_ff;
   assign rsp_last               = rsp_last_ff;

endmodule

// File: hdl/bitmap_row_pixel_decoder.sv
// Top level of the bitmap row pixel decoder: configuration registers, front, queue, back.
//
// The req channel takes one item per transfer: either a palette write
// (req_command low) or one byte of bitmap row data (req_command high).
// The rsp channel carries one ARGB pixel per transfer with its column, a
// row-done flag, an out-of-range flag for palette indexes and a last flag
// marking the final pixel produced by a data byte. Both channels move a
// transfer on a rising edge where valid is high and stall is low.
// The csr port writes one of eight registers per cycle with csr_write high.
// The first pixel of a byte passes the job queue, the issue register and the
// result register before it shows on rsp_valid. Throughput: one input transfer
// per cycle while the back end keeps up; the back end issues one pixel per cycle
// unless rsp_stall holds it, a byte at 1, 2 or 4 bits per pixel yields up to 8,
// 4 or 2 pixels, and a four-entry job queue absorbs the difference before
// req_stall rises. Palette writes and palette reads run in order through the
// same queue. While rsp_stall is high with a result offered, the result register
// and the back end hold; the front keeps taking items until the queue fills.
// Reset clears the row counters, the queue and the valid flags and loads the
// register defaults; the palette holds nothing until it is written.
module bitmap_row_pixel_decoder import brpd_pkg::*; #(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [7:0]  req_data_byte,
   input  logic [7:0]  req_palette_index,
   input  logic [23:0] req_palette_color,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_pixel_argb,
   output logic [15:0] rsp_pixel_column,
   output logic        rsp_row_done,
   output logic        rsp_index_out_of_range,
   output logic        rsp_last,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   cfg_type cfg_ff;
   logic    q_full;
   logic    q_push;
   job_type q_job;
   logic    q_pop;
   logic    q_valid;
   job_type q_head;

   // Configuration registers; writes leave the datapath state alone.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bpp        <= 6'd8;
         cfg_ff.indexed    <= 1'b1;
         cfg_ff.pcount     <= 9'd256;
         cfg_ff.width      <= 16'd1;
         cfg_ff.red_mask   <= 32'h00FF_0000;
         cfg_ff.green_mask <= 32'h0000_FF00;
         cfg_ff.blue_mask  <= 32'h0000_00FF;
         cfg_ff.alpha_mask <= 32'h0000_0000;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_BITS_PER_PIXEL: cfg_ff.bpp        <= csr_data[5:0];
            CSR_INDEXED_MODE:   cfg_ff.indexed    <= csr_data[0];
            CSR_PALETTE_COUNT:  cfg_ff.pcount     <= csr_data[8:0];
            CSR_IMAGE_WIDTH:    cfg_ff.width      <= csr_data[15:0];
            CSR_RED_MASK:       cfg_ff.red_mask   <= csr_data;
            CSR_GREEN_MASK:     cfg_ff.green_mask <= csr_data;
            CSR_BLUE_MASK:      cfg_ff.blue_mask  <= csr_data;
            CSR_ALPHA_MASK:     cfg_ff.alpha_mask <= csr_data;
            default:            cfg_ff            <= cfg_ff;
         endcase
      end
   end

   // The front classifies each item and keeps the row position.
   brpd_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_data_byte     (req_data_byte),
      .req_palette_index (req_palette_index),
      .req_palette_color (req_palette_color),
      .cfg               (cfg_ff),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_job             (q_job)
   );

   // The queue lets the front run ahead while the back expands a byte into pixels.
   brpd_job_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (q_job),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_job   (q_head)
   );

   // The back owns the palette and produces one pixel per cycle unless rsp_stall holds it.
   brpd_back #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_back (
      .clock                  (clock),
      .reset                  (reset),
      .cfg                    (cfg_ff),
      .q_valid                (q_valid),
      .q_head                 (q_head),
      .q_pop                  (q_pop),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_pixel_argb         (rsp_pixel_argb),
      .rsp_pixel_column       (rsp_pixel_column),
      .rsp_row_done           (rsp_row_done),
      .rsp_index_out_of_range (rsp_index_out_of_range),
      .rsp_last               (rsp_last)
   );

endmodule

// File: hdl/brpd_checker.sv
// Port-level checker for the bitmap row pixel decoder and its bind statement.
`include "assert_macros.svh"

module brpd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_pixel_argb,
   input logic [15:0] rsp_pixel_column,
   input logic        rsp_index_out_of_range,
   input logic        rsp_last
);

   // A stalled result stays offered.
   `BRPD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "rsp_valid dropped while stalled")

   // An out-of-range palette index always yields a transparent black pixel.
   `BRPD_ASSERT_IMPLIES(a_oor_zero, clock, reset, rsp_valid && rsp_index_out_of_range, rsp_pixel_argb == 32'd0, "out-of-range pixel is not zero")

   // The pixels of one byte follow each other without a gap.
   `BRPD_ASSERT_NEXT(a_burst_gapless, clock, reset, rsp_valid && !rsp_stall && !rsp_last, rsp_valid, "gap inside the pixels of one byte")

   // Within one byte the column steps by one from pixel to pixel.
   `BRPD_ASSERT_NEXT(a_burst_column, clock, reset, rsp_valid && !rsp_stall && !rsp_last, rsp_pixel_column == 16'($past(rsp_pixel_column) + 16'd1), "column does not step by one within a byte")

endmodule

bind bitmap_row_pixel_decoder brpd_checker u_checker (
   .clock                  (clock),
   .reset                  (reset),
   .rsp_valid              (rsp_valid),
   .rsp_stall              (rsp_stall),
   .rsp_pixel_argb         (rsp_pixel_argb),
   .rsp_pixel_column       (rsp_pixel_column),
   .rsp_index_out_of_range (rsp_index_out_of_range),
   .rsp_last               (rsp_last)
);
